// ----- src/assert_macros.svh -----
// Assertion helpers used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VAU_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("vec3 arith unit assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define VAU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("vec3 arith unit assertion failed");

`endif

// ----- src/vau_pkg.sv -----
package vau_pkg;

	typedef enum logic [2:0] {
		OP_SUB   = 3'd0,
		OP_ADD   = 3'd1,
		OP_SCALE = 3'd2,
		OP_DIV   = 3'd3,
		OP_DOT   = 3'd4,
		OP_NEG   = 3'd5,
		OP_NORM  = 3'd6,
		OP_CROSS = 3'd7
	} op_t;

	localparam logic signed [65:0] SAT_MAX = 66'sd2147483647;
	localparam logic signed [65:0] SAT_MIN = -66'sd2147483648;

	typedef struct packed {
		logic signed [31:0] val;
		logic               sat;
	} sat_t;

	// Values carried from the merge stage down to the final stage.
	typedef struct packed {
		op_t              op;
		logic [2:0][31:0] pre_r;
		logic [31:0]      pre_dot;
		logic             pre_sat;
		logic [2:0]       num_neg;
		logic [2:0][31:0] num_mag;
		logic             scl_neg;
		logic [31:0]      scl_mag;
		logic             scl_zero;
	} carry_t;

	typedef struct packed {
		logic signed [31:0] r_x;
		logic signed [31:0] r_y;
		logic signed [31:0] r_z;
		logic signed [31:0] dot_out;
		logic               div_error;
		logic               saturated;
	} res_t;

	function automatic sat_t sat32(input logic signed [65:0] v);
		sat_t r;
		if (v > SAT_MAX) begin
			r.val = 32'sh7fffffff;
			r.sat = 1'b1;
		end else if (v < SAT_MIN) begin
			r.val = 32'sh80000000;
			r.sat = 1'b1;
		end else begin
			r.val = v[31:0];
			r.sat = 1'b0;
		end
		return r;
	endfunction

endpackage

// ----- src/vau_in_if.sv -----
interface vau_in_if;
	logic               valid;
	logic               ready;
	logic [2:0]         op;
	logic signed [31:0] a_x;
	logic signed [31:0] a_y;
	logic signed [31:0] a_z;
	logic signed [31:0] b_x;
	logic signed [31:0] b_y;
	logic signed [31:0] b_z;
	logic signed [31:0] scalar_in;

	modport source (output valid, op, a_x, a_y, a_z, b_x, b_y, b_z, scalar_in, input ready);
	modport sink (input valid, op, a_x, a_y, a_z, b_x, b_y, b_z, scalar_in, output ready);
endinterface

// ----- src/vau_out_if.sv -----
interface vau_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] r_x;
	logic signed [31:0] r_y;
	logic signed [31:0] r_z;
	logic signed [31:0] dot_out;
	logic               div_error;
	logic               saturated;

	modport source (output valid, r_x, r_y, r_z, dot_out, div_error, saturated, input ready);
	modport sink (input valid, r_x, r_y, r_z, dot_out, div_error, saturated, output ready);
endinterface

// ----- src/vau_lane.sv -----
// One lane: two signed products, then their exact difference.
module vau_lane (
	input  logic               clk,
	input  logic               en,
	input  logic signed [31:0] x0,
	input  logic signed [31:0] y0,
	input  logic signed [31:0] x1,
	input  logic signed [31:0] y1,
	output logic signed [64:0] diff_s2
);
	logic signed [63:0] p0_s1;
	logic signed [63:0] p1_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			p0_s1   <= x0 * y0;
			p1_s1   <= x1 * y1;
			diff_s2 <= 65'(p0_s1) - 65'(p1_s1);
		end
	end
endmodule

// ----- src/vau_sqrt.sv -----
// Pipelined integer square root, two radicand bits per stage.
module vau_sqrt (
	input  logic        clk,
	input  logic        en,
	input  logic [63:0] rad,
	output logic [31:0] root
);
	logic [35:0] rem_q  [32];
	logic [31:0] root_q [32];
	logic [63:0] rad_q  [32];

	for (genvar k = 0; k < 32; k++) begin : g_stage
		logic [35:0] prem;
		logic [31:0] proot;
		logic [63:0] prad;
		logic [35:0] cur;
		logic [35:0] trial;

		if (k == 0) begin : g_first
			assign prem  = '0;
			assign proot = '0;
			assign prad  = rad;
		end else begin : g_next
			assign prem  = rem_q[k-1];
			assign proot = root_q[k-1];
			assign prad  = rad_q[k-1];
		end

		assign cur   = {prem[33:0], prad[63:62]};
		assign trial = {2'b00, proot, 2'b01};

		always_ff @(posedge clk) begin
			if (en) begin
				rad_q[k] <= {prad[61:0], 2'b00};
				if (cur >= trial) begin
					rem_q[k]  <= cur - trial;
					root_q[k] <= {proot[30:0], 1'b1};
				end else begin
					rem_q[k]  <= cur;
					root_q[k] <= {proot[30:0], 1'b0};
				end
			end
		end
	end

	assign root = root_q[31];
endmodule

// ----- src/vau_div.sv -----
// Pipelined unsigned restoring divider, one quotient bit per stage.
module vau_div #(
	parameter int DW = 48
) (
	input  logic          clk,
	input  logic          en,
	input  logic [DW-1:0] dvd,
	input  logic [31:0]   dvs,
	output logic [DW-1:0] quo
);
	// Each stage shifts the dividend out at the top and the quotient in at the bottom.
	logic [31:0]   rem_q [DW];
	logic [DW-1:0] dq_q  [DW];
	logic [31:0]   dvs_q [DW];

	for (genvar k = 0; k < DW; k++) begin : g_stage
		logic [31:0]   prem;
		logic [DW-1:0] pdq;
		logic [31:0]   pdvs;
		logic [32:0]   cur;
		logic          qbit;

		if (k == 0) begin : g_first
			assign prem = '0;
			assign pdq  = dvd;
			assign pdvs = dvs;
		end else begin : g_next
			assign prem = rem_q[k-1];
			assign pdq  = dq_q[k-1];
			assign pdvs = dvs_q[k-1];
		end

		assign cur  = {prem, pdq[DW-1]};
		assign qbit = (cur >= {1'b0, pdvs});

		always_ff @(posedge clk) begin
			if (en) begin
				dvs_q[k] <= pdvs;
				dq_q[k]  <= {pdq[DW-2:0], qbit};
				rem_q[k] <= qbit ? 32'(cur - {1'b0, pdvs}) : cur[31:0];
			end
		end
	end

	assign quo = dq_q[DW-1];
endmodule

// ----- src/vec3_arith_unit_top.sv -----
// Three-component vector ALU in signed fixed point with FRAC_BITS fraction bits.
// Transactions arrive on req (op, A, B, scalar) and leave on rsp with one result
// per request, in order: r_x/r_y/r_z, dot_out, div_error and saturated.
// Every op takes the same path, so all ops have the same latency from the accepting
// edge to the first edge at which the result is shown. Throughput is one
// transaction per cycle while the output buffer is not full.
// Three lanes hold the multipliers and the dividers, one per vector component;
// a merge stage forms the dot product and the sum of squares, a 32-stage
// square root feeds the length to the dividers, and the 32 + FRAC_BITS divider
// stages set most of the latency.
// The result lands in a two-entry output buffer. The pipeline moves as long as
// that buffer is not full, so a request is still taken while one result waits.
// When the receiver holds ready low and both entries fill, the pipeline freezes
// and req.ready drops until rsp takes a transaction.
// Reset clears the valid bits of all stages and empties the output buffer; data
// registers keep whatever they held.
module vec3_arith_unit_top #(
	parameter int FRAC_BITS = 16
) (
	input logic      clk,
	input logic      arst_n,
	vau_in_if.sink   req,
	vau_out_if.source rsp
);
	localparam int DW  = 32 + FRAC_BITS;
	localparam int LAT = 35 + DW;

	logic en;
	logic [LAT-1:0] vld_q;

	// Output buffer.
	vau_pkg::res_t ent0_q, ent1_q, res_new;
	logic [1:0]    cnt_q;
	logic          push, pop;

	assign en        = (cnt_q != 2'd2);
	assign req.ready = en;
	assign push      = en && vld_q[LAT-1];
	assign pop       = (cnt_q != 2'd0) && rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], req.valid};
		end
	end

	// Stage one inputs: pick the operands that each lane multiplies.
	logic signed [31:0] a_v [3];
	logic signed [31:0] b_v [3];
	vau_pkg::op_t       op_in;

	assign a_v[0] = req.a_x;
	assign a_v[1] = req.a_y;
	assign a_v[2] = req.a_z;
	assign b_v[0] = req.b_x;
	assign b_v[1] = req.b_y;
	assign b_v[2] = req.b_z;
	assign op_in  = vau_pkg::op_t'(req.op);

	logic signed [64:0] d_s2 [3];

	for (genvar i = 0; i < 3; i++) begin : g_lane
		localparam int J1 = (i + 1) % 3;
		localparam int J2 = (i + 2) % 3;
		logic signed [31:0] x0, y0, x1, y1;

		always_comb begin
			x0 = '0;
			y0 = '0;
			x1 = '0;
			y1 = '0;
			case (op_in)
				vau_pkg::OP_SCALE: begin
					x0 = req.scalar_in;
					y0 = b_v[i];
				end
				vau_pkg::OP_DOT: begin
					x0 = a_v[i];
					y0 = b_v[i];
				end
				vau_pkg::OP_NORM: begin
					x0 = a_v[i];
					y0 = a_v[i];
				end
				vau_pkg::OP_CROSS: begin
					x0 = a_v[J1];
					y0 = b_v[J2];
					x1 = a_v[J2];
					y1 = b_v[J1];
				end
				default: begin
					x0 = '0;
				end
			endcase
		end

		vau_lane u_lane (
			.clk    (clk),
			.en     (en),
			.x0     (x0),
			.y0     (y0),
			.x1     (x1),
			.y1     (y1),
			.diff_s2(d_s2[i])
		);
	end

	// Operands travel beside the lane pipeline.
	vau_pkg::op_t       op_s1, op_s2;
	logic signed [31:0] a_s1 [3];
	logic signed [31:0] b_s1 [3];
	logic signed [31:0] a_s2 [3];
	logic signed [31:0] b_s2 [3];
	logic signed [31:0] s_s1, s_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1 <= op_in;
			op_s2 <= op_s1;
			s_s1  <= req.scalar_in;
			s_s2  <= s_s1;
			a_s1  <= a_v;
			b_s1  <= b_v;
			a_s2  <= a_s1;
			b_s2  <= b_s1;
		end
	end

	// Merge stage: combine the lanes and prepare the divider operands.
	vau_pkg::carry_t    carry_c, carry_s3;
	logic [63:0]        sq_c, sq_s3;
	logic signed [65:0] dot_sum;
	logic signed [65:0] sh_v [3];
	logic signed [65:0] pre_v [3];
	logic signed [31:0] num_v [3];
	vau_pkg::sat_t      sr [3];
	vau_pkg::sat_t      sd;

	always_comb begin
		dot_sum = 66'(d_s2[0]) + 66'(d_s2[1]) + 66'(d_s2[2]);
		sq_c    = d_s2[0][63:0] + d_s2[1][63:0] + d_s2[2][63:0];
		for (int i = 0; i < 3; i++) begin
			sh_v[i] = 66'(d_s2[i]) >>> FRAC_BITS;
			case (op_s2)
				vau_pkg::OP_SUB:   pre_v[i] = 66'(a_s2[i]) - 66'(b_s2[i]);
				vau_pkg::OP_ADD:   pre_v[i] = 66'(a_s2[i]) + 66'(b_s2[i]);
				vau_pkg::OP_NEG:   pre_v[i] = -66'(a_s2[i]);
				vau_pkg::OP_SCALE,
				vau_pkg::OP_CROSS: pre_v[i] = sh_v[i];
				default:           pre_v[i] = '0;
			endcase
			sr[i]  = vau_pkg::sat32(pre_v[i]);
			num_v[i] = (op_s2 == vau_pkg::OP_DIV) ? b_s2[i] : a_s2[i];
			carry_c.pre_r[i]   = sr[i].val;
			carry_c.num_neg[i] = num_v[i][31];
			carry_c.num_mag[i] = num_v[i][31] ? 32'(-num_v[i]) : num_v[i];
		end
		sd = vau_pkg::sat32((op_s2 == vau_pkg::OP_DOT) ? (dot_sum >>> FRAC_BITS) : 66'sd0);
		carry_c.op       = op_s2;
		carry_c.pre_dot  = sd.val;
		carry_c.pre_sat  = sr[0].sat | sr[1].sat | sr[2].sat | sd.sat;
		carry_c.scl_neg  = s_s2[31];
		carry_c.scl_mag  = s_s2[31] ? 32'(-s_s2) : s_s2;
		carry_c.scl_zero = (s_s2 == 32'sd0);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			carry_s3 <= carry_c;
			sq_s3    <= sq_c;
		end
	end

	// Square root of the sum of squares, with the carried values alongside.
	logic [31:0]     root;
	vau_pkg::carry_t sq_carry_q [32];

	vau_sqrt u_sqrt (
		.clk (clk),
		.en  (en),
		.rad (sq_s3),
		.root(root)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			sq_carry_q[0] <= carry_s3;
			for (int k = 1; k < 32; k++) begin
				sq_carry_q[k] <= sq_carry_q[k-1];
			end
		end
	end

	// Division lanes.
	vau_pkg::carry_t cs;
	logic [31:0]     dvs;
	logic            err_in;
	logic [DW-1:0]   quo [3];
	vau_pkg::carry_t dv_carry_q [DW];
	logic            err_q [DW];

	assign cs     = sq_carry_q[31];
	assign dvs    = (cs.op == vau_pkg::OP_DIV) ? cs.scl_mag : root;
	assign err_in = (cs.op == vau_pkg::OP_DIV) ? cs.scl_zero :
	                ((cs.op == vau_pkg::OP_NORM) && (root == 32'd0));

	for (genvar i = 0; i < 3; i++) begin : g_div
		vau_div #(.DW(DW)) u_div (
			.clk(clk),
			.en (en),
			.dvd({cs.num_mag[i], {FRAC_BITS{1'b0}}}),
			.dvs(dvs),
			.quo(quo[i])
		);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_carry_q[0] <= cs;
			err_q[0]      <= err_in;
			for (int k = 1; k < DW; k++) begin
				dv_carry_q[k] <= dv_carry_q[k-1];
				err_q[k]      <= err_q[k-1];
			end
		end
	end

	// Final stage: sign and saturate the quotients (zero on a division error), or pass the early results.
	vau_pkg::carry_t    cf;
	logic               errf;
	logic               qneg [3];
	logic signed [65:0] qv [3];
	vau_pkg::sat_t      sq_r [3];
	logic [2:0][31:0]   fin_r;
	logic               fin_sat;

	assign cf   = dv_carry_q[DW-1];
	assign errf = err_q[DW-1];

	always_comb begin
		fin_r   = cf.pre_r;
		fin_sat = cf.pre_sat;
		for (int i = 0; i < 3; i++) begin
			qneg[i] = (cf.op == vau_pkg::OP_DIV) ? (cf.num_neg[i] ^ cf.scl_neg) : cf.num_neg[i];
			qv[i]   = qneg[i] ? -$signed(66'(quo[i])) : $signed(66'(quo[i]));
			sq_r[i] = vau_pkg::sat32(qv[i]);
		end
		if (cf.op == vau_pkg::OP_DIV || cf.op == vau_pkg::OP_NORM) begin
			if (errf) begin
				fin_r   = '0;
				fin_sat = 1'b0;
			end else begin
				for (int i = 0; i < 3; i++) begin
					fin_r[i] = sq_r[i].val;
				end
				fin_sat = sq_r[0].sat | sq_r[1].sat | sq_r[2].sat;
			end
		end
		res_new.r_x       = fin_r[0];
		res_new.r_y       = fin_r[1];
		res_new.r_z       = fin_r[2];
		res_new.dot_out   = cf.pre_dot;
		res_new.div_error = errf;
		res_new.saturated = fin_sat;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= 2'(cnt_q + {1'b0, push} - {1'b0, pop});
		end
	end

	always_ff @(posedge clk) begin
		if (push && pop) begin
			if (cnt_q == 2'd1) begin
				ent0_q <= res_new;
			end else begin
				ent0_q <= ent1_q;
				ent1_q <= res_new;
			end
		end else if (pop) begin
			ent0_q <= ent1_q;
		end else if (push) begin
			if (cnt_q == 2'd0) begin
				ent0_q <= res_new;
			end else begin
				ent1_q <= res_new;
			end
		end
	end

	assign rsp.valid     = (cnt_q != 2'd0);
	assign rsp.r_x       = ent0_q.r_x;
	assign rsp.r_y       = ent0_q.r_y;
	assign rsp.r_z       = ent0_q.r_z;
	assign rsp.dot_out   = ent0_q.dot_out;
	assign rsp.div_error = ent0_q.div_error;
	assign rsp.saturated = ent0_q.saturated;
endmodule

// ----- src/vau_checker.sv -----
`include "assert_macros.svh"

module vau_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               rsp_valid,
	input logic               rsp_ready,
	input logic signed [31:0] r_x,
	input logic signed [31:0] r_y,
	input logic signed [31:0] r_z,
	input logic signed [31:0] dot_out,
	input logic               div_error,
	input logic               saturated
);
	// A stalled transaction stays offered and unchanged.
	`VAU_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid)
	`VAU_ASSERT_NEXT(a_rsp_stable, clk, arst_n, rsp_valid && !rsp_ready, $stable(r_x) && $stable(r_y) && $stable(r_z) && $stable(dot_out) && $stable(div_error) && $stable(saturated))

	// A division error leaves every value at zero and nothing clipped.
	`VAU_ASSERT_SAME(a_err_zero, clk, arst_n, rsp_valid && div_error, r_x == 0 && r_y == 0 && r_z == 0 && dot_out == 0 && !saturated)

	// Only the dot product drives dot_out, and it leaves the vector at zero.
	`VAU_ASSERT_SAME(a_dot_alone, clk, arst_n, rsp_valid && dot_out != 0, r_x == 0 && r_y == 0 && r_z == 0 && !div_error)
endmodule

bind vec3_arith_unit_top vau_checker u_vau_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready),
	.r_x      (rsp.r_x),
	.r_y      (rsp.r_y),
	.r_z      (rsp.r_z),
	.dot_out  (rsp.dot_out),
	.div_error(rsp.div_error),
	.saturated(rsp.saturated)
);

// ----- test/tb_vec3_arith_unit_top.sv -----
`timescale 1ns / 1ps

module tb_vec3_arith_unit_top;

	// Fraction bits of the unit under test; the predictor uses the same value.
	localparam int FRAC = 16;
	// Edge-to-result latency, equal to LAT in the top level.
	localparam int PIPE_DEPTH = 35 + 32 + FRAC;
	localparam int CYCLE_LIMIT = 600000;
	localparam int RANDOM_COUNT = 1030;

	// One request transaction as the testbench keeps it.
	typedef struct {
		vau_pkg::op_t op;
		logic [31:0]  a [3];
		logic [31:0]  b [3];
		logic [31:0]  scl;
	} vec_req_t;

	// One row of the directed table: a request and, where it is obvious, its result.
	typedef struct {
		vec_req_t      req;
		bit            typed;
		vau_pkg::res_t res;
	} vec_row_t;

	logic clk;
	logic arst_n;

	vau_in_if  req ();
	vau_out_if rsp ();

	vec3_arith_unit_top #(.FRAC_BITS(FRAC)) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req.sink),
		.rsp    (rsp.source)
	);

	// Expected results, oldest first, and the result tied to the request on the bus.
	vau_pkg::res_t vec_results_due [$];
	vau_pkg::res_t offered_result;
	vec_row_t      directed_rows [$];

	int  error_count;
	int  cycle_count;
	int  sent_count;
	int  checked_count;
	int  op_count [8];
	bit  stimulus_done;
	bit  long_stall_done;

	// The clock runs free from time zero.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Integer square root, rounded down, of a 64-bit unsigned value.
	function automatic logic [63:0] floor_sqrt(input logic [63:0] s);
		logic [63:0] root;
		logic [63:0] bitv;
		root = '0;
		bitv = 64'd1 << 62;
		while (bitv > s)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (s >= root + bitv) begin
				s = s - (root + bitv);
				root = (root >> 1) + bitv;
			end else begin
				root = root >> 1;
			end
			bitv = bitv >> 2;
		end
		return root;
	endfunction

	// Clip a wide value to signed 32 bits and note any clipping in the flag.
	function automatic logic [31:0] clip32(input logic signed [127:0] v, inout logic flag);
		if (v > 128'sd2147483647) begin
			flag = 1'b1;
			return 32'h7fffffff;
		end
		if (v < -128'sd2147483648) begin
			flag = 1'b1;
			return 32'h80000000;
		end
		return v[31:0];
	endfunction

	// Computes the vector ALU result for one request. Intermediate values are held
	// at 128 bits, the sum of squares at 64, so products and sums are exact and >>>
	// rounds toward minus infinity while / truncates toward zero, as the unit does.
	function automatic vau_pkg::res_t vec_alu_result(input vec_req_t q);
		logic signed [127:0] av [3];
		logic signed [127:0] bv [3];
		logic signed [127:0] rv [3];
		logic signed [127:0] sv;
		logic signed [127:0] dv;
		logic signed [127:0] lenv;
		logic [63:0]         sumsq;
		logic                err;
		logic                clipped;
		vau_pkg::res_t       res;
		err = 1'b0;
		clipped = 1'b0;
		dv = 0;
		sumsq = '0;
		for (int i = 0; i < 3; i++) begin
			av[i] = $signed(q.a[i]);
			bv[i] = $signed(q.b[i]);
			rv[i] = 0;
		end
		sv = $signed(q.scl);
		case (q.op)
			vau_pkg::OP_SUB: begin
				for (int i = 0; i < 3; i++) rv[i] = av[i] - bv[i];
			end
			vau_pkg::OP_ADD: begin
				for (int i = 0; i < 3; i++) rv[i] = av[i] + bv[i];
			end
			vau_pkg::OP_SCALE: begin
				for (int i = 0; i < 3; i++) rv[i] = (sv * bv[i]) >>> FRAC;
			end
			vau_pkg::OP_DIV: begin
				if (sv == 0)
					err = 1'b1;
				else
					for (int i = 0; i < 3; i++) rv[i] = (bv[i] <<< FRAC) / sv;
			end
			vau_pkg::OP_DOT: begin
				dv = (av[0] * bv[0] + av[1] * bv[1] + av[2] * bv[2]) >>> FRAC;
			end
			vau_pkg::OP_NEG: begin
				for (int i = 0; i < 3; i++) rv[i] = -av[i];
			end
			vau_pkg::OP_NORM: begin
				for (int i = 0; i < 3; i++) sumsq = sumsq + 64'(av[i] * av[i]);
				lenv = 0;
				lenv[63:0] = floor_sqrt(sumsq);
				if (lenv == 0)
					err = 1'b1;
				else
					for (int i = 0; i < 3; i++) rv[i] = (av[i] <<< FRAC) / lenv;
			end
			default: begin
				rv[0] = (av[1] * bv[2] - av[2] * bv[1]) >>> FRAC;
				rv[1] = (av[2] * bv[0] - av[0] * bv[2]) >>> FRAC;
				rv[2] = (av[0] * bv[1] - av[1] * bv[0]) >>> FRAC;
			end
		endcase
		res.r_x = clip32(rv[0], clipped);
		res.r_y = clip32(rv[1], clipped);
		res.r_z = clip32(rv[2], clipped);
		res.dot_out = clip32(dv, clipped);
		res.div_error = err;
		res.saturated = clipped;
		return res;
	endfunction

	function automatic vec_req_t make_req(input vau_pkg::op_t op,
			input logic [31:0] ax, ay, az, bx, by, bz, scl);
		vec_req_t q;
		q.op = op;
		q.a[0] = ax; q.a[1] = ay; q.a[2] = az;
		q.b[0] = bx; q.b[1] = by; q.b[2] = bz;
		q.scl = scl;
		return q;
	endfunction

	function automatic vau_pkg::res_t make_res(input logic [31:0] rx, ry, rz, dotv,
			input logic err, clipped);
		vau_pkg::res_t r;
		r.r_x = rx; r.r_y = ry; r.r_z = rz; r.dot_out = dotv;
		r.div_error = err; r.saturated = clipped;
		return r;
	endfunction

	function automatic void add_row(input vec_req_t q, input bit typed,
			input vau_pkg::res_t r);
		vec_row_t row;
		row.req = q;
		row.typed = typed;
		row.res = r;
		directed_rows.push_back(row);
	endfunction

	// Random component: mostly moderate magnitudes so results stay in range, some
	// full-width values to toggle every bit and reach the clipping paths, and a
	// few zeros.
	function automatic logic [31:0] rand_comp();
		case ($urandom_range(0, 9))
			0, 1:    return $urandom;
			2:       return 32'd0;
			3:       return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
			4, 5:    return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
			default: return 32'($signed($urandom_range(0, 1 << 25)) - (1 << 24));
		endcase
	endfunction

	function automatic vec_req_t rand_req();
		vec_req_t q;
		q.op = vau_pkg::op_t'($urandom_range(0, 7));
		for (int i = 0; i < 3; i++) begin
			q.a[i] = rand_comp();
			q.b[i] = rand_comp();
		end
		q.scl = rand_comp();
		// Now and then a zero vector or zero divisor, the error cases.
		if ($urandom_range(0, 15) == 0) begin
			q.a[0] = '0; q.a[1] = '0; q.a[2] = '0;
		end
		if ($urandom_range(0, 15) == 0)
			q.scl = '0;
		return q;
	endfunction

	task automatic check_field(input string name, input logic [31:0] exp_v,
			input logic [31:0] got_v);
		if (exp_v !== got_v) begin
			$error("%s mismatch: expected %0d (0x%08h), got %0d (0x%08h)", name,
				$signed(exp_v), exp_v, $signed(got_v), got_v);
			error_count++;
		end
	endtask

	// Scoreboard. A predicted result is queued on each accepted request and each
	// accepted response transaction is compared with the oldest one. Everything is
	// sampled at the rising edge, before the nonblocking updates of that edge.
	always @(posedge clk) begin
		vau_pkg::res_t want;
		if (arst_n) begin
			if (req.valid && req.ready)
				vec_results_due.push_back(offered_result);
			if (rsp.valid && rsp.ready) begin
				if (vec_results_due.size() == 0) begin
					$error("response transaction with no request outstanding");
					error_count++;
				end else begin
					want = vec_results_due.pop_front();
					check_field("r_x", want.r_x, rsp.r_x);
					check_field("r_y", want.r_y, rsp.r_y);
					check_field("r_z", want.r_z, rsp.r_z);
					check_field("dot_out", want.dot_out, rsp.dot_out);
					check_field("div_error", 32'(want.div_error), 32'(rsp.div_error));
					check_field("saturated", 32'(want.saturated), 32'(rsp.saturated));
					checked_count++;
				end
			end
		end
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				vec_results_due.size());
			$display("** vec3_arith_unit_top: FAILED **");
			$finish;
		end
	end

	// Receiver. It stalls at random, short stalls far more often than long ones,
	// with alternate windows of the run free of stalls. Once, after a couple
	// hundred results, it holds ready low for a long stretch while the sender keeps
	// offering, so the output buffer and pipeline fill and the request side must
	// back up.
	initial begin
		int stall_left;
		stall_left = 0;
		rsp.ready = 1'b0;
		@(posedge clk iff arst_n);
		forever begin
			if (!long_stall_done && checked_count >= 200 && !stimulus_done) begin
				rsp.ready <= 1'b0;
				repeat (3 * PIPE_DEPTH) @(posedge clk);
				long_stall_done = 1'b1;
			end
			if (stall_left > 0) begin
				rsp.ready <= 1'b0;
				stall_left--;
			end else if (((cycle_count / 400) % 2 == 0) || $urandom_range(0, 3) != 0) begin
				rsp.ready <= 1'b1;
			end else begin
				rsp.ready <= 1'b0;
				stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
					: $urandom_range(0, 2);
			end
			@(posedge clk);
		end
	end

	// Offers one request and holds it until the unit takes it; returns at the
	// accepting edge with valid still high.
	task automatic offer_request(input vec_req_t q, input vau_pkg::res_t want);
		req.op <= q.op;
		req.a_x <= q.a[0]; req.a_y <= q.a[1]; req.a_z <= q.a[2];
		req.b_x <= q.b[0]; req.b_y <= q.b[1]; req.b_z <= q.b[2];
		req.scalar_in <= q.scl;
		offered_result <= want;
		req.valid <= 1'b1;
		op_count[q.op]++;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		sent_count++;
	endtask

	// Idle gap after a transaction: none within every other block of 100 requests,
	// otherwise short ones with an occasional long pause.
	task automatic sender_gap(input int idx);
		int gap;
		if ((idx / 100) % 2 == 1)
			gap = 0;
		else if ($urandom_range(0, 19) == 0)
			gap = $urandom_range(10, 40);
		else
			gap = $urandom_range(0, 2);
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	initial begin
		vec_req_t q;
		int       wait_cycles;
		error_count = 0;
		cycle_count = 0;
		sent_count = 0;
		checked_count = 0;
		stimulus_done = 1'b0;
		long_stall_done = 1'b0;
		foreach (op_count[i]) op_count[i] = 0;
		req.valid = 1'b0;
		req.op = vau_pkg::OP_SUB;
		req.a_x = '0; req.a_y = '0; req.a_z = '0;
		req.b_x = '0; req.b_y = '0; req.b_z = '0;
		req.scalar_in = '0;
		offered_result = '0;

		// Directed table. Rows with an obvious answer carry it; the rest go
		// through the predictor.
		add_row(make_req(vau_pkg::OP_ADD, 32'h7fffffff, 0, 0, 32'h7fffffff, 0, 0, 0), 1,
			make_res(32'h7fffffff, 0, 0, 0, 0, 1));
		add_row(make_req(vau_pkg::OP_SUB, 32'h80000000, 0, 0, 1, 0, 0, 0), 1,
			make_res(32'h80000000, 0, 0, 0, 0, 1));
		add_row(make_req(vau_pkg::OP_DIV, 0, 0, 0, 32'h10000, 32'h20000, 32'h30000, 0), 1,
			make_res(0, 0, 0, 0, 1, 0));
		add_row(make_req(vau_pkg::OP_NORM, 0, 0, 0, 5, 6, 7, 8), 1,
			make_res(0, 0, 0, 0, 1, 0));
		add_row(make_req(vau_pkg::OP_NEG, 32'h80000000, 0, 0, 0, 0, 0, 0), 1,
			make_res(32'h7fffffff, 0, 0, 0, 0, 1));
		add_row(make_req(vau_pkg::OP_SCALE, 0, 0, 0, 3, -5, 7, 32'h10000), 1,
			make_res(3, -5, 7, 0, 0, 0));
		add_row(make_req(vau_pkg::OP_DOT, 32'h10000, 0, 0, 32'h20000, 0, 0, 0), 1,
			make_res(0, 0, 0, 32'h20000, 0, 0));
		add_row(make_req(vau_pkg::OP_NORM, 32'h30000, 32'h40000, 0, 0, 0, 0, 0), 1,
			make_res(39321, 52428, 0, 0, 0, 0));
		add_row(make_req(vau_pkg::OP_CROSS, 32'h10000, 0, 0, 0, 32'h10000, 0, 0), 1,
			make_res(0, 0, 32'h10000, 0, 0, 0));
		add_row(make_req(vau_pkg::OP_SUB, 32'h7fffffff, 32'h80000000, 0, 32'h80000000,
			32'h7fffffff, 0, 0), 0, '0);
		add_row(make_req(vau_pkg::OP_ADD, 32'h80000000, 32'hffffffff, 1, 32'h80000000, 1,
			32'hffffffff, 0), 0, '0);
		add_row(make_req(vau_pkg::OP_SCALE, 0, 0, 0, 32'h80000000, 32'h7fffffff, -1,
			32'h80000000), 0, '0);
		add_row(make_req(vau_pkg::OP_SCALE, 0, 0, 0, -3, 3, 32'h7fffffff, 32'h8000), 0, '0);
		add_row(make_req(vau_pkg::OP_DIV, 0, 0, 0, 32'h80000000, 32'h7fffffff, -7, -1),
			0, '0);
		add_row(make_req(vau_pkg::OP_DIV, 0, 0, 0, 32'h80000000, 1, -1, 32'h7fffffff),
			0, '0);
		add_row(make_req(vau_pkg::OP_DOT, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
			32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0), 0, '0);
		add_row(make_req(vau_pkg::OP_DOT, 32'h80000000, 3, -1, 32'h7fffffff, -3, 1, 0),
			0, '0);
		add_row(make_req(vau_pkg::OP_NEG, 32'h7fffffff, -1, 0, 0, 0, 0, 0), 0, '0);
		add_row(make_req(vau_pkg::OP_NORM, 32'h80000000, 32'h80000000, 32'h80000000,
			0, 0, 0, 0), 0, '0);
		add_row(make_req(vau_pkg::OP_NORM, 0, 0, 1, 0, 0, 0, 0), 0, '0);
		add_row(make_req(vau_pkg::OP_NORM, 32'h7fffffff, -1, 0, 0, 0, 0, 0), 0, '0);
		add_row(make_req(vau_pkg::OP_CROSS, 32'h80000000, 32'h7fffffff, 32'h80000000,
			32'h7fffffff, 32'h80000000, 32'h7fffffff, 0), 0, '0);
		add_row(make_req(vau_pkg::OP_CROSS, -1, 2, -3, 4, -5, 6, 0), 0, '0);

		// Reset is asserted at time zero and released once.
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			offer_request(directed_rows[i].req, directed_rows[i].typed ? directed_rows[i].res
				: vec_alu_result(directed_rows[i].req));
			sender_gap(i);
		end
		for (int i = 0; i < RANDOM_COUNT; i++) begin
			q = rand_req();
			offer_request(q, vec_alu_result(q));
			sender_gap(i);
		end
		req.valid <= 1'b0;
		stimulus_done = 1'b1;

		// Drain the pipeline, then keep watching for any stray result.
		wait_cycles = 0;
		while (vec_results_due.size() != 0 && wait_cycles < 200 * PIPE_DEPTH) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (2 * PIPE_DEPTH) @(posedge clk);

		$display("%0d request transactions sent, %0d results checked (sub %0d, add %0d,",
			sent_count, checked_count, op_count[vau_pkg::OP_SUB], op_count[vau_pkg::OP_ADD]);
		$display("  scale %0d, divide %0d, dot %0d, negate %0d, normalize %0d, cross %0d)",
			op_count[vau_pkg::OP_SCALE], op_count[vau_pkg::OP_DIV],
			op_count[vau_pkg::OP_DOT], op_count[vau_pkg::OP_NEG],
			op_count[vau_pkg::OP_NORM], op_count[vau_pkg::OP_CROSS]);
		if (vec_results_due.size() != 0) begin
			$error("%0d expected results never arrived", vec_results_due.size());
			error_count++;
		end
		if (error_count == 0)
			$display("** vec3_arith_unit_top: PASSED **");
		else
			$display("** vec3_arith_unit_top: FAILED **");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+src
src/vau_pkg.sv
src/vau_in_if.sv
src/vau_out_if.sv
src/vau_lane.sv
src/vau_sqrt.sv
src/vau_div.sv
src/vec3_arith_unit_top.sv
src/vau_checker.sv
test/tb_vec3_arith_unit_top.sv
